>>> rtl/gss_pkg.sv
// gss_pkg: shared widths, codes, constants and word types of the golden-section search block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
package gss_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int COUNT_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int PROD_WIDTH      = 2 * DATA_WIDTH;
   localparam int GOLD_FRAC       = 30;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // (sqrt(5) - 1) / 2 in unsigned q2.30, held in a signed product-width word
   localparam logic signed [PROD_WIDTH-1:0] GOLD_Q30 = PROD_WIDTH'(663608942);
   localparam logic signed [PROD_WIDTH-1:0] HALF_Q30 = PROD_WIDTH'(1) <<< (GOLD_FRAC - 1);

   localparam logic OP_START = 1'b0;
   localparam logic OP_VALUE = 1'b1;

   localparam logic KIND_PROBE  = 1'b0;
   localparam logic KIND_RESULT = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TOLERANCE       = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LOWER_BOUND     = CSR_INDEX_WIDTH'(1);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_BOUND     = CSR_INDEX_WIDTH'(2);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ITERATION_LIMIT = CSR_INDEX_WIDTH'(3);

   typedef struct packed {
      logic [DATA_WIDTH-1:0]         tolerance;
      logic signed [DATA_WIDTH-1:0]  lower_bound;
      logic signed [DATA_WIDTH-1:0]  upper_bound;
      logic [COUNT_WIDTH-1:0]        iteration_limit;
   } cfg_type;

   typedef struct packed {
      logic                          start;
      logic signed [DATA_WIDTH-1:0]  value;
   } req_item_type;

   typedef struct packed {
      logic                          kind;
      logic signed [DATA_WIDTH-1:0]  point;
      logic [DATA_WIDTH-1:0]         width;
      logic [COUNT_WIDTH-1:0]        iterations;
   } rsp_item_type;

endpackage

>>> rtl/gss_req_queue.sv
// gss_req_queue: front part, takes request words, decodes the operation, holds them in a short queue
// depends on gss_pkg
`timescale 1ns / 1ps
module gss_req_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_operation,
   input  logic signed [gss_pkg::DATA_WIDTH-1:0] req_value,
   output logic                          item_valid,
   output gss_pkg::req_item_type         item,
   input  logic                          item_take
);
   import gss_pkg::*;

   req_item_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]  count_ff, count_in;
   logic                        push_ok, pop_ok;
   req_item_type                decoded;

   assign req_full   = (count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = entries_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = item_take && item_valid;

   always_comb begin
      decoded.start = (req_operation == OP_START);
      decoded.value = req_value;
   end

   always_comb begin
      wr_ptr_in = push_ok ? QUEUE_PTR_WIDTH'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? QUEUE_PTR_WIDTH'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      unique case ({push_ok, pop_ok})
         2'b10:   count_in = QUEUE_CNT_WIDTH'(count_ff + 1'b1);
         2'b01:   count_in = QUEUE_CNT_WIDTH'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

>>> rtl/gss_engine.sv
// gss_engine: back part, keeps the bracket and probe state and carries out each queued word
// depends on gss_pkg; fed by gss_req_queue, feeds gss_rsp_queue
`timescale 1ns / 1ps
module gss_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  gss_pkg::cfg_type       cfg,
   input  logic                   item_valid,
   input  gss_pkg::req_item_type  item,
   output logic                   item_take,
   input  logic                   rsp_space,
   output logic                   rsp_put,
   output gss_pkg::rsp_item_type  rsp_item
);
   import gss_pkg::*;

   typedef enum logic [1:0] {ST_TAKE, ST_DIFF, ST_MULT, ST_ROUND} state_type;
   typedef enum logic [1:0] {PH_IDLE, PH_WAIT1, PH_WAIT2, PH_RUN} phase_type;

   state_type                     state_ff, state_in;
   phase_type                     phase_ff, phase_in;
   logic signed [DATA_WIDTH-1:0]  a_ff, a_in, b_ff, b_in;
   logic signed [DATA_WIDTH-1:0]  x1_ff, x1_in, x2_ff, x2_in;
   logic signed [DATA_WIDTH-1:0]  y1_ff, y1_in, y2_ff, y2_in;
   logic                          pend_ff, pend_in;
   logic                          start_ff, start_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic signed [DATA_WIDTH:0]    diff_ff, diff_in;
   logic [DATA_WIDTH-1:0]         mag_ff, mag_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;

   logic signed [DATA_WIDTH-1:0]  y1_new, y2_new;
   logic                          go_on;
   logic signed [DATA_WIDTH:0]    mid_sum;
   logic signed [DATA_WIDTH:0]    diff_neg;
   logic signed [PROD_WIDTH-1:0]  diff_ext;
   logic signed [PROD_WIDTH-1:0]  rounded;
   logic signed [DATA_WIDTH-1:0]  step;
   logic signed [DATA_WIDTH-1:0]  up_probe, low_probe;

   always_comb begin
      y1_new   = (phase_ff == PH_RUN && pend_ff) ? item.value : y1_ff;
      y2_new   = (phase_ff == PH_WAIT2 || (phase_ff == PH_RUN && !pend_ff)) ? item.value
                                                                             : y2_ff;
      go_on    = (mag_ff > cfg.tolerance) && (count_ff < cfg.iteration_limit);
      mid_sum  = {a_ff[DATA_WIDTH-1], a_ff} + {b_ff[DATA_WIDTH-1], b_ff};
      diff_neg = -diff_ff;
      diff_ext = {{(PROD_WIDTH-DATA_WIDTH-1){diff_ff[DATA_WIDTH]}}, diff_ff};
      rounded  = prod_ff + HALF_Q30;
      step     = rounded[GOLD_FRAC+DATA_WIDTH-1:GOLD_FRAC];
      up_probe  = DATA_WIDTH'(a_ff + step);
      low_probe = DATA_WIDTH'(b_ff - step);
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      x1_in     = x1_ff;
      x2_in     = x2_ff;
      y1_in     = y1_ff;
      y2_in     = y2_ff;
      pend_in   = pend_ff;
      start_in  = start_ff;
      count_in  = count_ff;
      diff_in   = diff_ff;
      mag_in    = mag_ff;
      prod_in   = prod_ff;
      item_take = 1'b0;
      rsp_put   = 1'b0;
      rsp_item  = '{kind: KIND_PROBE, point: '0, width: '0, iterations: '0};

      unique case (state_ff)
         ST_TAKE: begin
            if (item_valid && rsp_space) begin
               item_take = 1'b1;
               if (item.start) begin
                  a_in     = cfg.lower_bound;
                  b_in     = cfg.upper_bound;
                  count_in = '0;
                  pend_in  = 1'b1;
                  start_in = 1'b1;
                  phase_in = PH_WAIT1;
                  state_in = ST_DIFF;
               end else begin
                  unique case (phase_ff)
                     PH_IDLE: begin
                        // value with no search running is dropped
                     end
                     PH_WAIT1: begin
                        y1_in          = item.value;
                        pend_in        = 1'b0;
                        phase_in       = PH_WAIT2;
                        rsp_put        = 1'b1;
                        rsp_item.point = x2_ff;
                     end
                     PH_WAIT2, PH_RUN: begin
                        y1_in = y1_new;
                        y2_in = y2_new;
                        if (go_on) begin
                           count_in = COUNT_WIDTH'(count_ff + 1'b1);
                           phase_in = PH_RUN;
                           start_in = 1'b0;
                           state_in = ST_DIFF;
                           if (y1_new < y2_new) begin
                              a_in    = x2_ff;
                              x2_in   = x1_ff;
                              y2_in   = y1_new;
                              pend_in = 1'b1;
                           end else begin
                              b_in    = x1_ff;
                              x1_in   = x2_ff;
                              y1_in   = y2_new;
                              pend_in = 1'b0;
                           end
                        end else begin
                           phase_in            = PH_IDLE;
                           rsp_put             = 1'b1;
                           rsp_item.kind       = KIND_RESULT;
                           rsp_item.point      = mid_sum[DATA_WIDTH:1];
                           rsp_item.width      = mag_ff;
                           rsp_item.iterations = count_ff;
                        end
                     end
                  endcase
               end
            end
         end
         ST_DIFF: begin
            diff_in  = {b_ff[DATA_WIDTH-1], b_ff} - {a_ff[DATA_WIDTH-1], a_ff};
            state_in = ST_MULT;
         end
         ST_MULT: begin
            prod_in  = diff_ext * GOLD_Q30;
            mag_in   = diff_ff[DATA_WIDTH] ? diff_neg[DATA_WIDTH-1:0]
                                           : diff_ff[DATA_WIDTH-1:0];
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rsp_space) begin
               rsp_put  = 1'b1;
               state_in = ST_TAKE;
               if (start_ff) begin
                  x1_in          = up_probe;
                  x2_in          = low_probe;
                  rsp_item.point = up_probe;
               end else if (pend_ff) begin
                  x1_in          = up_probe;
                  rsp_item.point = up_probe;
               end else begin
                  x2_in          = low_probe;
                  rsp_item.point = low_probe;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
         phase_ff <= PH_IDLE;
         a_ff     <= '0;
         b_ff     <= '0;
         x1_ff    <= '0;
         x2_ff    <= '0;
         y1_ff    <= '0;
         y2_ff    <= '0;
         pend_ff  <= 1'b0;
         start_ff <= 1'b0;
         count_ff <= '0;
         mag_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         x1_ff    <= x1_in;
         x2_ff    <= x2_in;
         y1_ff    <= y1_in;
         y2_ff    <= y2_in;
         pend_ff  <= pend_in;
         start_ff <= start_in;
         count_ff <= count_in;
         mag_ff   <= mag_in;
      end
      diff_ff <= diff_in;
      prod_ff <= prod_in;
   end

endmodule

>>> rtl/gss_rsp_queue.sv
// gss_rsp_queue: short result queue between the engine and the result ports
// depends on gss_pkg
`timescale 1ns / 1ps
module gss_rsp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   put,
   input  gss_pkg::rsp_item_type  put_item,
   output logic                   space,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output gss_pkg::rsp_item_type  head
);
   import gss_pkg::*;

   rsp_item_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0]  count_ff, count_in;
   logic                        push_ok, pop_ok;

   assign space     = (count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign head      = entries_ff[rd_ptr_ff];
   assign push_ok   = put && space;
   assign pop_ok    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = push_ok ? QUEUE_PTR_WIDTH'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? QUEUE_PTR_WIDTH'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      unique case ({push_ok, pop_ok})
         2'b10:   count_in = QUEUE_CNT_WIDTH'(count_ff + 1'b1);
         2'b01:   count_in = QUEUE_CNT_WIDTH'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= put_item;
      end
   end

endmodule

>>> rtl/golden_section_search.sv
// golden_section_search: top level, configuration registers and the front, engine and result queue
// depends on gss_pkg, gss_req_queue, gss_engine, gss_rsp_queue
//
// usage: push a start word (operation 0) to begin a search on [lower_bound, upper_bound];
// the block answers with a probe point (kind 0). evaluate the function there and push the
// value back (operation 1); each value gives either the next probe or, once the bracket is
// within tolerance or the iteration limit is reached, a result word (kind 1) holding the
// midpoint, the bracket width and the iteration count. a value with no search running is dropped.
// request side: push/full queue of two words; result side: empty/pop queue of two words.
// the engine answers the value of the first probe and a final result as it takes the word;
// a start word or a value that narrows the bracket first goes through the steps below.
// one word per cycle goes into the request queue while it is not full; a word that needs a
// new step holds the engine, which takes no other word, through difference, multiply by the
// golden ratio, rounding and add, all through one shared multiplier.
// configuration: csr writes are always ready and should be made while no search is running.
// reset (synchronous) empties both queues, loads the default registers and leaves no search
// running. a stalled receiver fills the result queue; the engine then waits and the request
// queue raises full.
`timescale 1ns / 1ps
module golden_section_search (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic                                    req_operation,
   input  logic signed [gss_pkg::DATA_WIDTH-1:0]   req_value,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic                                    rsp_kind,
   output logic signed [gss_pkg::DATA_WIDTH-1:0]   rsp_point,
   output logic [gss_pkg::DATA_WIDTH-1:0]          rsp_width,
   output logic [gss_pkg::COUNT_WIDTH-1:0]         rsp_iterations,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [gss_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [gss_pkg::DATA_WIDTH-1:0]          csr_data
);
   import gss_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          item_valid, item_take;
   req_item_type  item;
   logic          rsp_space, rsp_put;
   rsp_item_type  rsp_item, rsp_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TOLERANCE:       cfg_in.tolerance       = csr_data;
            CSR_LOWER_BOUND:     cfg_in.lower_bound     = csr_data;
            CSR_UPPER_BOUND:     cfg_in.upper_bound     = csr_data;
            CSR_ITERATION_LIMIT: cfg_in.iteration_limit = csr_data[COUNT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance       <= DATA_WIDTH'(66);
         cfg_ff.lower_bound     <= '0;
         cfg_ff.upper_bound     <= DATA_WIDTH'(65536);
         cfg_ff.iteration_limit <= COUNT_WIDTH'(100);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gss_req_queue u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_operation (req_operation),
      .req_value     (req_value),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take)
   );

   gss_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_space  (rsp_space),
      .rsp_put    (rsp_put),
      .rsp_item   (rsp_item)
   );

   gss_rsp_queue u_back (
      .clock     (clock),
      .reset     (reset),
      .put       (rsp_put),
      .put_item  (rsp_item),
      .space     (rsp_space),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .head      (rsp_head)
   );

   assign rsp_kind       = rsp_head.kind;
   assign rsp_point      = rsp_head.point;
   assign rsp_width      = rsp_head.width;
   assign rsp_iterations = rsp_head.iterations;

endmodule

>>> tb/tb.sv
// tb: self-checking bench for golden_section_search, driving start and value words and checking
// every probe and final result against an in-bench model of the bracket search
// depends on gss_pkg and the golden_section_search rtl
`timescale 1ns / 1ps
module tb;
   import gss_pkg::*;

   localparam int          CYCLE_LIMIT   = 600000;
   localparam int          RANDOM_WORDS  = 950;
   localparam int          SETTLE_CYCLES = 20;
   localparam longint      GOLDEN_Q30    = 64'sd663608942;
   localparam longint      ROUND_Q30     = 64'sd536870912;

   typedef enum logic [1:0] {
      SEARCH_IDLE,
      WAIT_UPPER,
      WAIT_LOWER,
      NARROWING
   } search_phase_type;

   typedef struct {
      logic                   op;
      logic [DATA_WIDTH-1:0]  value;
   } search_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   logic                            req_operation = OP_START;
   logic signed [DATA_WIDTH-1:0]    req_value = '0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   logic                            rsp_kind;
   logic signed [DATA_WIDTH-1:0]    rsp_point;
   logic [DATA_WIDTH-1:0]           rsp_width;
   logic [COUNT_WIDTH-1:0]          rsp_iterations;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]      csr_index = CSR_TOLERANCE;
   logic [DATA_WIDTH-1:0]           csr_data = '0;

   golden_section_search dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_kind       (rsp_kind),
      .rsp_point      (rsp_point),
      .rsp_width      (rsp_width),
      .rsp_iterations (rsp_iterations),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // bracket search model state and register copies
   search_phase_type srch_phase = SEARCH_IDLE;
   longint          lo_end = 0;
   longint          hi_end = 0;
   longint          probe_hi = 0;
   longint          probe_lo = 0;
   longint          fval_hi = 0;
   longint          fval_lo = 0;
   logic            await_hi = 1'b0;
   int unsigned     step_count = 0;
   longint          cfg_tol = 66;
   longint          cfg_lo = 0;
   longint          cfg_hi = 65536;
   int unsigned     cfg_steps = 100;

   rsp_item_type    answer_queue[$];
   search_word_type outgoing_words[$];
   int              failures = 0;
   int unsigned     words_queued = 0;
   int unsigned     words_started = 0;
   int unsigned     words_accepted = 0;
   logic            hold_sender = 1'b0;
   int unsigned     cycle_count = 0;

   function automatic longint gold_offset();
      return ((hi_end - lo_end) * GOLDEN_Q30 + ROUND_Q30) >>> 30;
   endfunction

   function automatic void push_answer(input logic kind, input longint point,
                                       input longint span, input int unsigned steps);
      rsp_item_type ans;
      ans.kind       = kind;
      ans.point      = DATA_WIDTH'(point);
      ans.width      = DATA_WIDTH'(span);
      ans.iterations = COUNT_WIDTH'(steps);
      answer_queue.push_back(ans);
   endfunction

   function automatic void narrow_or_finish();
      longint span;
      span = hi_end - lo_end;
      if (span < 0) span = -span;
      if (span > cfg_tol && step_count < cfg_steps) begin
         step_count = step_count + 1;
         srch_phase = NARROWING;
         if (fval_hi < fval_lo) begin
            lo_end   = probe_lo;
            probe_lo = probe_hi;
            fval_lo  = fval_hi;
            probe_hi = lo_end + gold_offset();
            await_hi = 1'b1;
            push_answer(KIND_PROBE, probe_hi, 0, 0);
         end else begin
            hi_end   = probe_hi;
            probe_hi = probe_lo;
            fval_hi  = fval_lo;
            probe_lo = hi_end - gold_offset();
            await_hi = 1'b0;
            push_answer(KIND_PROBE, probe_lo, 0, 0);
         end
      end else begin
         srch_phase = SEARCH_IDLE;
         push_answer(KIND_RESULT, (lo_end + hi_end) >>> 1, span, step_count);
      end
   endfunction

   function automatic void advance_search(input logic op, input logic signed [DATA_WIDTH-1:0] v);
      longint d;
      if (op == OP_START) begin
         lo_end     = cfg_lo;
         hi_end     = cfg_hi;
         step_count = 0;
         d          = gold_offset();
         probe_hi   = lo_end + d;
         probe_lo   = hi_end - d;
         await_hi   = 1'b1;
         srch_phase = WAIT_UPPER;
         push_answer(KIND_PROBE, probe_hi, 0, 0);
      end else begin
         case (srch_phase)
            WAIT_UPPER: begin
               fval_hi    = longint'(v);
               await_hi   = 1'b0;
               srch_phase = WAIT_LOWER;
               push_answer(KIND_PROBE, probe_lo, 0, 0);
            end
            WAIT_LOWER: begin
               fval_lo = longint'(v);
               narrow_or_finish();
            end
            NARROWING: begin
               if (await_hi) fval_hi = longint'(v);
               else fval_lo = longint'(v);
               narrow_or_finish();
            end
            default: ;
         endcase
      end
   endfunction

   // sender: bursts of random length with random gaps
   logic            push_next;
   search_word_type word_now;
   int unsigned     burst_left = 1;
   int unsigned     gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         push_next = req_push;
         if (req_push && !req_full) begin
            advance_search(req_operation, req_value);
            words_accepted++;
            push_next = 1'b0;
         end
         if (!push_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (!hold_sender && outgoing_words.size() != 0) begin
               word_now = outgoing_words.pop_front();
               req_operation <= word_now.op;
               req_value     <= word_now.value;
               push_next = 1'b1;
               words_started++;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 7) == 0) begin
                  burst_left = $urandom_range(50, 150);
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = $urandom_range(0, 5);
               end
            end
         end
         req_push <= push_next;
      end
   end

   // receiver: runs of pop high or low, now and then a long stretch with no stall
   rsp_item_type    want;
   int unsigned     pop_run = 0;
   logic            pop_level = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (answer_queue.size() == 0) begin
               $error("unexpected word: kind %0d point %h", rsp_kind, rsp_point);
               failures++;
            end else begin
               want = answer_queue.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d actual %0d", want.kind, rsp_kind);
                  failures++;
               end
               if (rsp_point !== want.point) begin
                  $error("point: expected %h actual %h", want.point, rsp_point);
                  failures++;
               end
               if (rsp_width !== want.width) begin
                  $error("width: expected %h actual %h", want.width, rsp_width);
                  failures++;
               end
               if (rsp_iterations !== want.iterations) begin
                  $error("iterations: expected %0d actual %0d", want.iterations, rsp_iterations);
                  failures++;
               end
            end
         end
         if (pop_run > 0) begin
            pop_run--;
         end else if ($urandom_range(0, 7) == 0) begin
            pop_level = 1'b1;
            pop_run   = 200;
         end else begin
            pop_level = ($urandom_range(0, 2) != 0);
            pop_run   = $urandom_range(1, 24);
         end
         rsp_pop <= pop_level;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TOLERANCE:       cfg_tol   = longint'(data);
         CSR_LOWER_BOUND:     cfg_lo    = longint'($signed(data));
         CSR_UPPER_BOUND:     cfg_hi    = longint'($signed(data));
         CSR_ITERATION_LIMIT: cfg_steps = int'(data[COUNT_WIDTH-1:0]);
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [DATA_WIDTH-1:0] tol, input logic [DATA_WIDTH-1:0] lo,
                             input logic [DATA_WIDTH-1:0] hi, input logic [DATA_WIDTH-1:0] lim);
      write_reg(CSR_TOLERANCE, tol);
      write_reg(CSR_LOWER_BOUND, lo);
      write_reg(CSR_UPPER_BOUND, hi);
      write_reg(CSR_ITERATION_LIMIT, lim);
   endtask

   task automatic queue_word(input logic op, input logic [DATA_WIDTH-1:0] value);
      search_word_type w;
      w.op    = op;
      w.value = value;
      outgoing_words.push_back(w);
      words_queued++;
   endtask

   function automatic logic [DATA_WIDTH-1:0] rand_value();
      case ($urandom_range(0, 11))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_search(input int unsigned n);
      queue_word(OP_START, $urandom);
      repeat (n) queue_word(OP_VALUE, rand_value());
   endtask

   // all words sent, all answers in, then let the engine settle
   task automatic wait_quiet();
      while (!(words_accepted == words_queued && answer_queue.size() == 0)) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned      random_words;
      int unsigned      phase_no;
      int unsigned      n;
      int unsigned      span;
      logic [31:0]      tol_pick;
      logic [31:0]      lo_pick;
      logic [31:0]      hi_pick;
      logic [31:0]      lim_pick;
      logic [31:0]      swap;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // value with no search running
      queue_word(OP_VALUE, 32'h7FFF_FFFF);
      wait_quiet();

      // zero iteration limit
      set_config(32'd0, -32'sd65536, 32'sd65536, 32'd0);
      queue_word(OP_START, 32'h8000_0000);
      queue_word(OP_VALUE, 32'h8000_0000);
      queue_word(OP_VALUE, 32'h7FFF_FFFF);
      wait_quiet();

      // tolerance already met on the widest bracket
      set_config(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd65535);
      queue_word(OP_START, 32'hFFFF_FFFF);
      queue_word(OP_VALUE, 32'h0000_0001);
      queue_word(OP_VALUE, 32'h0000_0000);
      wait_quiet();

      // reversed bounds, then a start while busy
      set_config(32'd16, 32'sd327680, -32'sd196608, 32'd3);
      queue_word(OP_START, 32'd0);
      queue_word(OP_VALUE, 32'h7FFF_FFFF);
      queue_word(OP_VALUE, 32'h8000_0000);
      queue_word(OP_VALUE, 32'h0001_0000);
      queue_word(OP_VALUE, 32'hFFFF_0000);
      queue_word(OP_VALUE, 32'h0000_0005);
      queue_word(OP_START, 32'd0);
      queue_word(OP_VALUE, 32'h0000_0010);
      queue_word(OP_START, 32'd0);
      queue_word(OP_VALUE, 32'hFFFF_FFF0);
      queue_word(OP_VALUE, 32'h0000_0020);
      queue_word(OP_VALUE, 32'h0000_0001);
      queue_word(OP_VALUE, 32'h8000_0000);
      queue_word(OP_VALUE, 32'h7FFF_FFFF);
      wait_quiet();

      // widest bracket with narrowing
      set_config(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2);
      queue_word(OP_START, 32'd0);
      queue_word(OP_VALUE, 32'h0000_0003);
      queue_word(OP_VALUE, 32'h0000_0007);
      queue_word(OP_VALUE, 32'h0000_0002);
      queue_word(OP_VALUE, 32'h0000_0009);
      wait_quiet();

      random_words = 0;
      phase_no     = 0;
      while (random_words < RANDOM_WORDS) begin
         case ($urandom_range(0, 4))
            0:       tol_pick = '0;
            1:       tol_pick = 32'hFFFF_FFFF;
            2:       tol_pick = $urandom;
            default: tol_pick = $urandom_range(0, 1024);
         endcase
         lo_pick = 32'($urandom_range(0, 33554432)) - 32'd16777216;
         hi_pick = lo_pick + 32'($urandom_range(0, 16777216));
         case ($urandom_range(0, 5))
            0: begin
               lo_pick = 32'h8000_0000;
               hi_pick = 32'h7FFF_FFFF;
            end
            1: begin
               lo_pick = $urandom;
               hi_pick = $urandom;
            end
            default: ;
         endcase
         if ($urandom_range(0, 4) == 0) begin
            swap    = lo_pick;
            lo_pick = hi_pick;
            hi_pick = swap;
         end
         case ($urandom_range(0, 9))
            0:       lim_pick = '0;
            1:       lim_pick = 32'd65535;
            2:       lim_pick = $urandom_range(0, 65535);
            default: lim_pick = $urandom_range(1, 12);
         endcase
         set_config(tol_pick, lo_pick, hi_pick, lim_pick);

         repeat ($urandom_range(1, 4)) begin
            span = (lim_pick > 12) ? 12 : lim_pick;
            n    = span + 2;
            case ($urandom_range(0, 7))
               0:       n = $urandom_range(0, n - 1);
               1:       n = n + $urandom_range(1, 3);
               default: ;
            endcase
            queue_search(n);
            random_words += 1 + n;
         end
         if ($urandom_range(0, 5) == 0) begin
            repeat (2) queue_word(1'($urandom_range(0, 1)), rand_value());
         end

         // sender holds off until the block has drained
         if (phase_no % 4 == 0) begin
            while (outgoing_words.size() > words_queued % 3) @(posedge clock);
            hold_sender <= 1'b1;
            @(posedge clock);
            while (!(words_started == words_accepted && answer_queue.size() == 0))
               @(posedge clock);
            hold_sender <= 1'b0;
         end
         wait_quiet();
         phase_no++;
      end

      if (answer_queue.size() != 0) begin
         $error("%0d answers never arrived", answer_queue.size());
         failures++;
      end
      if (failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/gss_pkg.sv
rtl/gss_req_queue.sv
rtl/gss_engine.sv
rtl/gss_rsp_queue.sv
rtl/golden_section_search.sv
tb/tb.sv
